// File: src/tcpt_pkg.sv
package tcpt_pkg;

  localparam int unsigned NumTimers = 8;
  localparam int unsigned CountW    = 32;
  localparam int unsigned MaskW     = 8;
  localparam int unsigned IdxW      = 3;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [CountW-1:0] CyclesPerTickRst   = 32'd72000;
  localparam logic [CountW-1:0] CyclesPerSecondRst = 32'd72000000;

  typedef enum logic [1:0] {
    CmdTick = 2'd0,
    CmdArm  = 2'd1,
    CmdStop = 2'd2,
    CmdAck  = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegCyclesPerTick   = 1'd0,
    RegCyclesPerSecond = 1'd1
  } cfg_reg_e;

  // One accepted transaction as seen by the state modules
  typedef struct packed {
    logic              fire;
    cmd_e              cmd;
    logic [IdxW-1:0]   idx;
    logic [CountW-1:0] period;
  } op_t;

  typedef struct packed {
    logic [CountW-1:0] cycles_per_tick;
    logic [CountW-1:0] cycles_per_second;
  } cfg_t;

endpackage

// File: src/tcpt_clock.sv
module tcpt_clock (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tcpt_pkg::op_t                op_i,
  input  tcpt_pkg::cfg_t               cfg_i,
  output logic [tcpt_pkg::CountW-1:0]  ticks_o,
  output logic [tcpt_pkg::CountW-1:0]  ticks_next_o,
  output logic [tcpt_pkg::CountW-1:0]  seconds_next_o,
  output logic                         second_passed_o
);

  logic [tcpt_pkg::CountW-1:0] ticks_q, ticks_d;
  logic [tcpt_pkg::CountW-1:0] seconds_q, seconds_d;
  logic [tcpt_pkg::CountW-1:0] rem_q, rem_d;
  logic [tcpt_pkg::CountW-1:0] rem_sum;
  logic                        is_tick;
  logic                        sec_hit;

  assign is_tick = op_i.fire && (op_i.cmd == tcpt_pkg::CmdTick);
  assign rem_sum = rem_q + cfg_i.cycles_per_tick;
  assign sec_hit = (rem_sum >= cfg_i.cycles_per_second);

  always_comb begin
    ticks_d   = ticks_q;
    seconds_d = seconds_q;
    rem_d     = rem_q;
    if (is_tick) begin
      ticks_d = ticks_q + 32'd1;
      if (sec_hit) begin
        rem_d     = rem_sum - cfg_i.cycles_per_second;
        seconds_d = seconds_q + 32'd1;
      end else begin
        rem_d = rem_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q   <= '0;
      seconds_q <= '0;
      rem_q     <= '0;
    end else begin
      ticks_q   <= ticks_d;
      seconds_q <= seconds_d;
      rem_q     <= rem_d;
    end
  end

  assign ticks_o         = ticks_q;
  assign ticks_next_o    = ticks_d;
  assign seconds_next_o  = seconds_d;
  assign second_passed_o = is_tick && sec_hit;

endmodule

// File: src/tcpt_timers.sv
module tcpt_timers (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tcpt_pkg::op_t                op_i,
  input  logic [tcpt_pkg::CountW-1:0]  ticks_i,
  input  logic [tcpt_pkg::CountW-1:0]  ticks_next_i,
  output logic [tcpt_pkg::MaskW-1:0]   fired_mask_o,
  output logic [tcpt_pkg::MaskW-1:0]   elapsed_mask_o
);

  logic [tcpt_pkg::NumTimers-1:0] armed_q, armed_d;
  logic [tcpt_pkg::NumTimers-1:0] elapsed_q, elapsed_d;
  logic [tcpt_pkg::NumTimers-1:0] fired;
  logic [tcpt_pkg::CountW-1:0]    deadline_q [tcpt_pkg::NumTimers];
  logic [tcpt_pkg::CountW-1:0]    period_q   [tcpt_pkg::NumTimers];
  logic                           is_tick;

  assign is_tick = op_i.fire && (op_i.cmd == tcpt_pkg::CmdTick);

  for (genvar k = 0; k < int'(tcpt_pkg::NumTimers); k++) begin : g_lane
    logic sel;
    logic arm, stop, ack;

    assign sel  = op_i.fire && (32'(op_i.idx) == 32'(k));
    assign arm  = sel && (op_i.cmd == tcpt_pkg::CmdArm);
    assign stop = sel && (op_i.cmd == tcpt_pkg::CmdStop);
    assign ack  = sel && (op_i.cmd == tcpt_pkg::CmdAck);

    // Compare against the tick count after this tick's increment
    assign fired[k] = is_tick && armed_q[k] && (ticks_next_i >= deadline_q[k]);

    always_comb begin
      armed_d[k]   = armed_q[k];
      elapsed_d[k] = elapsed_q[k];
      if (fired[k]) begin
        elapsed_d[k] = 1'b1;
      end else if (arm) begin
        armed_d[k]   = 1'b1;
        elapsed_d[k] = 1'b0;
      end else if (stop) begin
        armed_d[k]   = 1'b0;
        elapsed_d[k] = 1'b0;
      end else if (ack) begin
        elapsed_d[k] = 1'b0;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        armed_q[k]   <= 1'b0;
        elapsed_q[k] <= 1'b0;
      end else begin
        armed_q[k]   <= armed_d[k];
        elapsed_q[k] <= elapsed_d[k];
      end
    end

    // Deadline and period hold until the first arm
    always_ff @(posedge clk_i) begin
      if (arm) begin
        period_q[k]   <= op_i.period;
        deadline_q[k] <= ticks_i + op_i.period;
      end else if (fired[k]) begin
        deadline_q[k] <= deadline_q[k] + period_q[k];
      end
    end
  end

  for (genvar m = 0; m < int'(tcpt_pkg::MaskW); m++) begin : g_mask
    if (m < int'(tcpt_pkg::NumTimers)) begin : g_have
      assign fired_mask_o[m]   = fired[m];
      assign elapsed_mask_o[m] = elapsed_d[m];
    end else begin : g_none
      assign fired_mask_o[m]   = 1'b0;
      assign elapsed_mask_o[m] = 1'b0;
    end
  end

endmodule

// File: src/tick_clock_with_periodic_timers_top.sv
// Channel  Handshake               Payload
// in       in_valid_i/in_ready_o   cmd_i, timer_index_i, period_ticks_i
// out      out_valid_o/out_ready_i tick_count_o, seconds_count_o, fired_mask_o,
//                                  elapsed_mask_o, second_passed_o
// cfg      cfg_we_i                cfg_index_i, cfg_wdata_i
//
// State updates at the accepting edge and the result lands in the output
// register on the same edge. One transaction per cycle is sustained while
// out_ready_i is high; the output register is the only stage.
// in_ready_o is high while the output register is empty or being drained.
// Reset clears counts, remainder, armed and elapsed bits and loads the
// default cycle settings; timer deadlines and periods are not reset.
module tick_clock_with_periodic_timers_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tcpt_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [tcpt_pkg::CountW-1:0]         cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          cmd_i,
  input  logic [tcpt_pkg::IdxW-1:0]           timer_index_i,
  input  logic [tcpt_pkg::CountW-1:0]         period_ticks_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [tcpt_pkg::CountW-1:0]         tick_count_o,
  output logic [tcpt_pkg::CountW-1:0]         seconds_count_o,
  output logic [tcpt_pkg::MaskW-1:0]          fired_mask_o,
  output logic [tcpt_pkg::MaskW-1:0]          elapsed_mask_o,
  output logic                                second_passed_o
);

  tcpt_pkg::cfg_t              cfg_q;
  tcpt_pkg::op_t               op;
  logic                        out_valid_q;
  logic [tcpt_pkg::CountW-1:0] ticks, ticks_next, seconds_next;
  logic                        sec_passed;
  logic [tcpt_pkg::MaskW-1:0]  fired_mask, elapsed_mask;

  logic [tcpt_pkg::CountW-1:0] tick_count_q, seconds_count_q;
  logic [tcpt_pkg::MaskW-1:0]  fired_mask_q, elapsed_mask_q;
  logic                        second_passed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cycles_per_tick   <= tcpt_pkg::CyclesPerTickRst;
      cfg_q.cycles_per_second <= tcpt_pkg::CyclesPerSecondRst;
    end else if (cfg_we_i) begin
      unique case (tcpt_pkg::cfg_reg_e'(cfg_index_i))
        tcpt_pkg::RegCyclesPerTick:   cfg_q.cycles_per_tick   <= cfg_wdata_i;
        tcpt_pkg::RegCyclesPerSecond: cfg_q.cycles_per_second <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign op.fire    = in_valid_i && in_ready_o;
  assign op.cmd     = tcpt_pkg::cmd_e'(cmd_i);
  assign op.idx     = timer_index_i;
  assign op.period  = period_ticks_i;

  tcpt_clock u_clock (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .cfg_i           (cfg_q),
    .ticks_o         (ticks),
    .ticks_next_o    (ticks_next),
    .seconds_next_o  (seconds_next),
    .second_passed_o (sec_passed)
  );

  tcpt_timers u_timers (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .ticks_i        (ticks),
    .ticks_next_i   (ticks_next),
    .fired_mask_o   (fired_mask),
    .elapsed_mask_o (elapsed_mask)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op.fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the result with the transaction that produced it
  always_ff @(posedge clk_i) begin
    if (op.fire) begin
      tick_count_q    <= ticks_next;
      seconds_count_q <= seconds_next;
      fired_mask_q    <= fired_mask;
      elapsed_mask_q  <= elapsed_mask;
      second_passed_q <= sec_passed;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign tick_count_o    = tick_count_q;
  assign seconds_count_o = seconds_count_q;
  assign fired_mask_o    = fired_mask_q;
  assign elapsed_mask_o  = elapsed_mask_q;
  assign second_passed_o = second_passed_q;

endmodule

// File: src/tcpt_checker.sv
module tcpt_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [1:0]                   cmd_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [tcpt_pkg::CountW-1:0]  tick_count_o,
  input logic [tcpt_pkg::MaskW-1:0]   fired_mask_o,
  input logic                         second_passed_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tick_count_o))
    else $error("stalled result changed");

  // An empty output register never blocks input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted transaction produced no result");

  // Commands other than tick report no expiry and no second
  a_cmd_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (cmd_i != tcpt_pkg::CmdTick)
    |=> (fired_mask_o == '0) && !second_passed_o)
    else $error("command result reported a tick event");

endmodule

bind tick_clock_with_periodic_timers_top tcpt_checker u_tcpt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .cmd_i           (cmd_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .tick_count_o    (tick_count_o),
  .fired_mask_o    (fired_mask_o),
  .second_passed_o (second_passed_o)
);
